// ----- design/first_fit_word_allocator_core_assert.svh -----
// assertion macros for the first-fit word allocator core
// used by first_fit_word_allocator_core.sv; expects clk and arst_n in scope
`ifndef FIRST_FIT_WORD_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_WORD_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FFWA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define FFWA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ffwa_pkg.sv -----
// package for the first-fit word allocator core
// sizes, status codes and sequencer states; no dependencies
`default_nettype none

package ffwa_pkg;

	localparam int HEAP_WORDS   = 4096;
	localparam int LIST_ENTRIES = 64;
	localparam int WORD_BYTES   = 8;

	// fixed request and result field widths
	localparam int CMD_W    = 1;
	localparam int SIZE_W   = 16;
	localparam int ADDR_IN_W = 13;
	localparam int STAT_W   = 3;

	// derived widths
	localparam int ADDR_W  = $clog2(HEAP_WORDS);
	localparam int LEN_W   = $clog2(HEAP_WORDS + 1);
	localparam int IDX_W   = $clog2(LIST_ENTRIES);
	localparam int CNT_W   = $clog2(LIST_ENTRIES + 1);
	localparam int BYTE_SH = $clog2(WORD_BYTES);
	localparam int SUM_W   = SIZE_W + 1;
	localparam int WORDS_W = SUM_W - BYTE_SH;
	localparam int CMP_W   = (LEN_W > WORDS_W) ? LEN_W : WORDS_W;
	localparam int ACMP_W  = (ADDR_W > ADDR_IN_W) ? ADDR_W : ADDR_IN_W;

	localparam logic [ADDR_IN_W-1:0] NULL_ADDR = ADDR_IN_W'(HEAP_WORDS);

	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NOFIT    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NULL     = 3'd4;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CO_RD,
		S_CO_EV,
		S_CO_END,
		S_A_DEC,
		S_UI_RD,
		S_UI_EV,
		S_UI_PUT,
		S_FD_RD,
		S_FD_EV,
		S_SR_RD,
		S_SR_EV,
		S_F_DEC,
		S_FI_RD,
		S_FI_EV,
		S_FI_PUT,
		S_UD_RD,
		S_UD_EV,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- design/first_fit_word_allocator_core.sv -----
// first-fit word allocator core: sequencer, list memories and result register
// depends on ffwa_pkg and first_fit_word_allocator_core_assert.svh
//
// channel | signals                                   | direction
// request | in_valid in_ready cmd req_bytes address   | in
// result  | out_valid out_ready result_address status | out
//
// an allocate walks the free list to merge and pick the first fit, then the used list
// and, if the chunk is used whole, the free list; a free walks the used list, the free
// list and the used list again, each via the single registered read port of a list.
// reset leaves one free chunk covering the whole heap; no clearing pass is run.
// the next request is taken while a finished result waits on out_ready.
`default_nettype none

module first_fit_word_allocator_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [ffwa_pkg::CMD_W-1:0]     cmd,
	input  wire logic [ffwa_pkg::SIZE_W-1:0]    req_bytes,
	input  wire logic [ffwa_pkg::ADDR_IN_W-1:0] address,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [ffwa_pkg::ADDR_IN_W-1:0]      result_address,
	output logic [ffwa_pkg::STAT_W-1:0]         status
);

	localparam int AW  = ffwa_pkg::ADDR_W;
	localparam int LW  = ffwa_pkg::LEN_W;
	localparam int IW  = ffwa_pkg::IDX_W;
	localparam int CW  = ffwa_pkg::CNT_W;
	localparam int WW  = ffwa_pkg::WORDS_W;
	localparam int XW  = ffwa_pkg::CMP_W;
	localparam int QW  = ffwa_pkg::ACMP_W;
	localparam int RW  = ffwa_pkg::ADDR_IN_W;
	localparam int SW  = ffwa_pkg::STAT_W;
	localparam logic [CW-1:0] LIST_MAX = CW'(ffwa_pkg::LIST_ENTRIES);

	ffwa_pkg::state_t state_q, state_d;

	// list memories
	logic [AW-1:0] free_start_mem [ffwa_pkg::LIST_ENTRIES];
	logic [LW-1:0] free_len_mem   [ffwa_pkg::LIST_ENTRIES];
	logic [AW-1:0] used_start_mem [ffwa_pkg::LIST_ENTRIES];
	logic [LW-1:0] used_len_mem   [ffwa_pkg::LIST_ENTRIES];

	logic [AW-1:0] free_rs_q, used_rs_q;
	logic [LW-1:0] free_rl_q, used_rl_q;
	logic          free_rd0_q;
	logic          free0_q;

	// sequencer registers
	logic [WW-1:0]   words_q;
	logic [RW-1:0]   addr_q;
	logic [CW-1:0]   fc_q, uc_q, r_q, w_q, k_q;
	logic [AW-1:0]   cs_q, fs_q;
	logic [LW-1:0]   cl_q, fl_q;
	logic            found_q, tail_zero_q;
	logic [RW-1:0]   res_q;
	logic [SW-1:0]   stat_q;
	logic            out_valid_q;
	logic [RW-1:0]   result_address_q;
	logic [SW-1:0]   status_q;

	// memory port controls
	logic          free_we, used_we;
	logic [IW-1:0] free_waddr, used_waddr, free_raddr, used_raddr;
	logic [AW-1:0] free_wstart, used_wstart;
	logic [LW-1:0] free_wlen, used_wlen;

	// shared arithmetic
	logic [ffwa_pkg::SUM_W-1:0] round_sum;
	logic [WW-1:0]   in_words;
	logic [AW-1:0]   free_dstart;
	logic [LW-1:0]   free_dlen;
	logic            adjacent;
	logic            fits;
	logic [AW-1:0]   tail_start;
	logic [LW-1:0]   tail_len;
	logic [CW-1:0]   r_inc, w_dec;
	logic            accept;

	assign accept    = in_valid && in_ready;
	assign round_sum = {1'b0, req_bytes} + ffwa_pkg::SUM_W'(ffwa_pkg::WORD_BYTES - 1);
	assign in_words  = WW'(round_sum >> ffwa_pkg::BYTE_SH);

	// entry 0 of the free list reads as the whole heap until first written
	assign free_dstart = (free_rd0_q && free0_q) ? '0 : free_rs_q;
	assign free_dlen   = (free_rd0_q && free0_q) ? LW'(ffwa_pkg::HEAP_WORDS) : free_rl_q;

	assign adjacent   = (LW'(cs_q) + cl_q) == LW'(free_dstart);
	assign fits       = !found_q && (XW'(cl_q) >= XW'(words_q));
	assign tail_start = AW'(XW'(fs_q) + XW'(words_q));
	assign tail_len   = LW'(XW'(fl_q) - XW'(words_q));
	assign r_inc      = r_q + CW'(1);
	assign w_dec      = w_q - CW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffwa_pkg::S_IDLE: begin
				if (accept) begin
					if (cmd == ffwa_pkg::CMD_ALLOC) begin
						state_d = (in_words == '0) ? ffwa_pkg::S_DONE : ffwa_pkg::S_CO_RD;
					end else begin
						state_d = (address == ffwa_pkg::NULL_ADDR) ? ffwa_pkg::S_DONE
							: ffwa_pkg::S_SR_RD;
					end
				end
			end
			ffwa_pkg::S_CO_RD: state_d = (r_q == fc_q) ? ffwa_pkg::S_CO_END : ffwa_pkg::S_CO_EV;
			ffwa_pkg::S_CO_EV: state_d = ffwa_pkg::S_CO_RD;
			ffwa_pkg::S_CO_END: state_d = ffwa_pkg::S_A_DEC;
			ffwa_pkg::S_A_DEC: begin
				state_d = (!found_q || uc_q >= LIST_MAX) ? ffwa_pkg::S_DONE : ffwa_pkg::S_UI_RD;
			end
			ffwa_pkg::S_UI_RD: state_d = (w_q == '0) ? ffwa_pkg::S_UI_PUT : ffwa_pkg::S_UI_EV;
			ffwa_pkg::S_UI_EV: state_d = (used_rs_q > fs_q) ? ffwa_pkg::S_UI_RD : ffwa_pkg::S_UI_PUT;
			ffwa_pkg::S_UI_PUT: state_d = tail_zero_q ? ffwa_pkg::S_FD_RD : ffwa_pkg::S_DONE;
			ffwa_pkg::S_FD_RD: state_d = (r_inc >= fc_q) ? ffwa_pkg::S_DONE : ffwa_pkg::S_FD_EV;
			ffwa_pkg::S_FD_EV: state_d = ffwa_pkg::S_FD_RD;
			ffwa_pkg::S_SR_RD: state_d = (r_q == uc_q) ? ffwa_pkg::S_DONE : ffwa_pkg::S_SR_EV;
			ffwa_pkg::S_SR_EV: begin
				state_d = (QW'(used_rs_q) == QW'(addr_q)) ? ffwa_pkg::S_F_DEC : ffwa_pkg::S_SR_RD;
			end
			ffwa_pkg::S_F_DEC: state_d = (fc_q >= LIST_MAX) ? ffwa_pkg::S_DONE : ffwa_pkg::S_FI_RD;
			ffwa_pkg::S_FI_RD: state_d = (w_q == '0) ? ffwa_pkg::S_FI_PUT : ffwa_pkg::S_FI_EV;
			ffwa_pkg::S_FI_EV: state_d = (free_dstart > fs_q) ? ffwa_pkg::S_FI_RD : ffwa_pkg::S_FI_PUT;
			ffwa_pkg::S_FI_PUT: state_d = ffwa_pkg::S_UD_RD;
			ffwa_pkg::S_UD_RD: state_d = (r_inc >= uc_q) ? ffwa_pkg::S_DONE : ffwa_pkg::S_UD_EV;
			ffwa_pkg::S_UD_EV: state_d = ffwa_pkg::S_UD_RD;
			ffwa_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ffwa_pkg::S_IDLE;
				end
			end
			default: state_d = ffwa_pkg::S_IDLE;
		endcase
	end

	// memory port controls and request ready
	always_comb begin
		in_ready    = 1'b0;
		free_we     = 1'b0;
		free_waddr  = w_q[IW-1:0];
		free_wstart = cs_q;
		free_wlen   = cl_q;
		free_raddr  = r_q[IW-1:0];
		used_we     = 1'b0;
		used_waddr  = w_q[IW-1:0];
		used_wstart = used_rs_q;
		used_wlen   = used_rl_q;
		used_raddr  = r_q[IW-1:0];
		case (state_q)
			ffwa_pkg::S_IDLE: in_ready = 1'b1;
			ffwa_pkg::S_CO_EV: free_we = (r_q != '0) && !adjacent;
			ffwa_pkg::S_CO_END: free_we = (r_q != '0);
			ffwa_pkg::S_A_DEC: begin
				free_we     = found_q && (uc_q < LIST_MAX) && (tail_len != '0);
				free_waddr  = k_q[IW-1:0];
				free_wstart = tail_start;
				free_wlen   = tail_len;
			end
			ffwa_pkg::S_UI_RD: used_raddr = w_dec[IW-1:0];
			ffwa_pkg::S_UI_EV: used_we = (used_rs_q > fs_q);
			ffwa_pkg::S_UI_PUT: begin
				used_we     = 1'b1;
				used_wstart = fs_q;
				used_wlen   = LW'(words_q);
			end
			ffwa_pkg::S_FD_RD: free_raddr = r_inc[IW-1:0];
			ffwa_pkg::S_FD_EV: begin
				free_we     = 1'b1;
				free_waddr  = r_q[IW-1:0];
				free_wstart = free_dstart;
				free_wlen   = free_dlen;
			end
			ffwa_pkg::S_FI_RD: free_raddr = w_dec[IW-1:0];
			ffwa_pkg::S_FI_EV: begin
				free_we     = (free_dstart > fs_q);
				free_wstart = free_dstart;
				free_wlen   = free_dlen;
			end
			ffwa_pkg::S_FI_PUT: begin
				free_we     = 1'b1;
				free_wstart = fs_q;
				free_wlen   = fl_q;
			end
			ffwa_pkg::S_UD_RD: used_raddr = r_inc[IW-1:0];
			ffwa_pkg::S_UD_EV: begin
				used_we    = 1'b1;
				used_waddr = r_q[IW-1:0];
			end
			default: ;
		endcase
	end

	// free list memory, registered read
	always_ff @(posedge clk) begin
		if (free_we) begin
			free_start_mem[free_waddr] <= free_wstart;
			free_len_mem[free_waddr]   <= free_wlen;
		end
		free_rs_q <= free_start_mem[free_raddr];
		free_rl_q <= free_len_mem[free_raddr];
	end

	// used list memory, registered read
	always_ff @(posedge clk) begin
		if (used_we) begin
			used_start_mem[used_waddr] <= used_wstart;
			used_len_mem[used_waddr]   <= used_wlen;
		end
		used_rs_q <= used_start_mem[used_raddr];
		used_rl_q <= used_len_mem[used_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffwa_pkg::S_IDLE;
			free0_q     <= 1'b1;
			free_rd0_q  <= 1'b0;
			fc_q        <= CW'(1);
			uc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			free_rd0_q <= (free_raddr == '0);
			if (free_we && free_waddr == '0) begin
				free0_q <= 1'b0;
			end
			case (state_q)
				ffwa_pkg::S_CO_END: fc_q <= (r_q == '0) ? '0 : w_q + CW'(1);
				ffwa_pkg::S_UI_PUT: uc_q <= uc_q + CW'(1);
				ffwa_pkg::S_FD_RD: begin
					if (r_inc >= fc_q) begin
						fc_q <= fc_q - CW'(1);
					end
				end
				ffwa_pkg::S_FI_PUT: fc_q <= fc_q + CW'(1);
				ffwa_pkg::S_UD_RD: begin
					if (r_inc >= uc_q) begin
						uc_q <= uc_q - CW'(1);
					end
				end
				default: ;
			endcase
			if (state_q == ffwa_pkg::S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ffwa_pkg::S_IDLE: begin
				words_q <= in_words;
				addr_q  <= address;
				r_q     <= '0;
				w_q     <= '0;
				found_q <= 1'b0;
				res_q   <= ffwa_pkg::NULL_ADDR;
				if (cmd == ffwa_pkg::CMD_ALLOC) begin
					stat_q <= ffwa_pkg::STAT_NOFIT;
				end else if (address == ffwa_pkg::NULL_ADDR) begin
					stat_q <= ffwa_pkg::STAT_NULL;
				end else begin
					stat_q <= ffwa_pkg::STAT_NOTFOUND;
				end
			end
			ffwa_pkg::S_CO_EV: begin
				r_q <= r_inc;
				if (r_q == '0) begin
					cs_q <= free_dstart;
					cl_q <= free_dlen;
				end else if (adjacent) begin
					cl_q <= cl_q + free_dlen;
				end else begin
					if (fits) begin
						found_q <= 1'b1;
						k_q     <= w_q;
						fs_q    <= cs_q;
						fl_q    <= cl_q;
					end
					w_q  <= w_q + CW'(1);
					cs_q <= free_dstart;
					cl_q <= free_dlen;
				end
			end
			ffwa_pkg::S_CO_END: begin
				if (r_q != '0 && fits) begin
					found_q <= 1'b1;
					k_q     <= w_q;
					fs_q    <= cs_q;
					fl_q    <= cl_q;
				end
			end
			ffwa_pkg::S_A_DEC: begin
				w_q         <= uc_q;
				tail_zero_q <= (tail_len == '0);
				if (found_q && uc_q >= LIST_MAX) begin
					stat_q <= ffwa_pkg::STAT_FULL;
				end
			end
			ffwa_pkg::S_UI_EV: begin
				if (used_rs_q > fs_q) begin
					w_q <= w_dec;
				end
			end
			ffwa_pkg::S_UI_PUT: begin
				r_q    <= k_q;
				stat_q <= ffwa_pkg::STAT_OK;
				res_q  <= RW'(fs_q);
			end
			ffwa_pkg::S_FD_EV: r_q <= r_inc;
			ffwa_pkg::S_SR_EV: begin
				if (QW'(used_rs_q) == QW'(addr_q)) begin
					k_q  <= r_q;
					fs_q <= used_rs_q;
					fl_q <= used_rl_q;
				end else begin
					r_q <= r_inc;
				end
			end
			ffwa_pkg::S_F_DEC: begin
				w_q <= fc_q;
				if (fc_q >= LIST_MAX) begin
					stat_q <= ffwa_pkg::STAT_FULL;
				end
			end
			ffwa_pkg::S_FI_EV: begin
				if (free_dstart > fs_q) begin
					w_q <= w_dec;
				end
			end
			ffwa_pkg::S_FI_PUT: begin
				r_q    <= k_q;
				stat_q <= ffwa_pkg::STAT_OK;
			end
			ffwa_pkg::S_UD_EV: r_q <= r_inc;
			default: ;
		endcase
	end

	// result register, loaded when the previous result has gone
	always_ff @(posedge clk) begin
		if (state_q == ffwa_pkg::S_DONE && (!out_valid_q || out_ready)) begin
			result_address_q <= res_q;
			status_q         <= stat_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_address = result_address_q;
	assign status         = status_q;

`include "first_fit_word_allocator_core_assert.svh"

	`FFWA_ASSERT_NOW(a_counts_bounded, 1'b1, (fc_q <= LIST_MAX) && (uc_q <= LIST_MAX), "list count above capacity")
	`FFWA_ASSERT_NOW(a_fail_is_null, out_valid && (status != ffwa_pkg::STAT_OK), result_address == ffwa_pkg::NULL_ADDR, "failed request returned an address")
	`FFWA_ASSERT_NOW(a_fit_large_enough, (state_q == ffwa_pkg::S_A_DEC) && found_q, XW'(fl_q) >= XW'(words_q), "chosen chunk smaller than request")
	`FFWA_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "request taken while busy")

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// testbench for the first-fit word allocator core: directed table, list fill and drain, then random requests
// depends on ffwa_pkg and first_fit_word_allocator_core; checks against an in-bench heap model
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import ffwa_pkg::*;

	localparam int N_RANDOM = 1000;

	typedef struct packed {
		logic [CMD_W-1:0]     op;
		logic [SIZE_W-1:0]    nbytes;
		logic [ADDR_IN_W-1:0] ptr;
	} heap_req_t;

	typedef struct packed {
		logic [ADDR_IN_W-1:0] addr;
		logic [STAT_W-1:0]    stat;
	} heap_res_t;

	// directed row; known marks rows whose result is typed in
	typedef struct {
		heap_req_t req;
		bit        known;
		heap_res_t res;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CMD_W-1:0]     cmd;
	logic [SIZE_W-1:0]    req_bytes;
	logic [ADDR_IN_W-1:0] address;
	logic                 out_valid;
	logic                 out_ready;
	logic [ADDR_IN_W-1:0] result_address;
	logic [STAT_W-1:0]    status;

	first_fit_word_allocator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .req_bytes(req_bytes), .address(address),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_address(result_address), .status(status)
	);

	// heap model state
	int unsigned fr_start[LIST_ENTRIES];
	int unsigned fr_len[LIST_ENTRIES];
	int unsigned fr_cnt;
	int unsigned us_start[LIST_ENTRIES];
	int unsigned us_len[LIST_ENTRIES];
	int unsigned us_cnt;

	heap_res_t pending_results[$];
	int        mismatches;
	bit        stim_done;

	function automatic void merge_free_chunks();
		int unsigned w;
		w = 0;
		for (int unsigned r = 0; r < fr_cnt; r++) begin
			if (w > 0 && fr_start[w-1] + fr_len[w-1] == fr_start[r]) begin
				fr_len[w-1] += fr_len[r];
			end else begin
				fr_start[w] = fr_start[r];
				fr_len[w]   = fr_len[r];
				w++;
			end
		end
		fr_cnt = w;
	endfunction

	// sorted insert into the free list (is_free) or the used list
	function automatic void chunk_insert(bit is_free, int unsigned s, int unsigned l);
		int unsigned pos;
		if (is_free) begin
			pos = fr_cnt;
			while (pos > 0 && fr_start[pos-1] > s) begin
				fr_start[pos] = fr_start[pos-1];
				fr_len[pos]   = fr_len[pos-1];
				pos--;
			end
			fr_start[pos] = s;
			fr_len[pos]   = l;
			fr_cnt++;
		end else begin
			pos = us_cnt;
			while (pos > 0 && us_start[pos-1] > s) begin
				us_start[pos] = us_start[pos-1];
				us_len[pos]   = us_len[pos-1];
				pos--;
			end
			us_start[pos] = s;
			us_len[pos]   = l;
			us_cnt++;
		end
	endfunction

	function automatic void chunk_remove(bit is_free, int unsigned idx);
		if (is_free) begin
			for (int unsigned k = idx; k + 1 < fr_cnt; k++) begin
				fr_start[k] = fr_start[k+1];
				fr_len[k]   = fr_len[k+1];
			end
			fr_cnt--;
		end else begin
			for (int unsigned k = idx; k + 1 < us_cnt; k++) begin
				us_start[k] = us_start[k+1];
				us_len[k]   = us_len[k+1];
			end
			us_cnt--;
		end
	endfunction

	function automatic heap_res_t apply_heap_request(heap_req_t rq);
		heap_res_t   r;
		int unsigned words, k, s, tail;
		bit          hit;
		r.addr = NULL_ADDR;
		r.stat = STAT_OK;
		hit    = 0;
		k      = 0;
		if (rq.op == CMD_ALLOC) begin
			words = (int'(rq.nbytes) + WORD_BYTES - 1) / WORD_BYTES;
			if (words == 0) begin
				r.stat = STAT_NOFIT;
			end else begin
				merge_free_chunks();
				for (k = 0; k < fr_cnt; k++) begin
					if (fr_len[k] >= words) begin
						hit = 1;
						break;
					end
				end
				if (!hit) begin
					r.stat = STAT_NOFIT;
				end else if (us_cnt >= LIST_ENTRIES) begin
					r.stat = STAT_FULL;
				end else begin
					s    = fr_start[k];
					tail = fr_len[k] - words;
					chunk_remove(1, k);
					chunk_insert(0, s, words);
					if (tail > 0) chunk_insert(1, s + words, tail);
					r.addr = ADDR_IN_W'(s);
				end
			end
		end else begin
			if (rq.ptr == NULL_ADDR) begin
				r.stat = STAT_NULL;
			end else begin
				for (k = 0; k < us_cnt; k++) begin
					if (us_start[k] == rq.ptr) begin
						hit = 1;
						break;
					end
				end
				if (!hit) begin
					r.stat = STAT_NOTFOUND;
				end else if (fr_cnt >= LIST_ENTRIES) begin
					r.stat = STAT_FULL;
				end else begin
					chunk_insert(1, us_start[k], us_len[k]);
					chunk_remove(0, k);
				end
			end
		end
		return r;
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("** first_fit_word_allocator_core: FAILED **");
		$finish;
	end

	// hand one request over, check a typed row against the model and queue the predicted result
	task automatic send_request(heap_req_t rq, bit known, heap_res_t typed);
		heap_res_t pred;
		in_valid  <= 1'b1;
		cmd       <= rq.op;
		req_bytes <= rq.nbytes;
		address   <= rq.ptr;
		do @(posedge clk); while (!in_ready);
		pred = apply_heap_request(rq);
		if (known && pred !== typed) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees: typed %h/%0d model %h/%0d",
					typed.addr, typed.stat, pred.addr, pred.stat);
		end
		pending_results.push_back(pred);
	endtask

	task automatic pause_sender();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	// pick a random request: mostly valid frees of live chunks and small allocs
	function automatic heap_req_t random_request();
		heap_req_t   rq;
		int unsigned pick;
		rq.op     = CMD_W'($urandom_range(0, 1));
		rq.nbytes = SIZE_W'($urandom);
		rq.ptr    = ADDR_IN_W'($urandom);
		pick      = $urandom_range(0, 99);
		if (rq.op == CMD_ALLOC) begin
			if (pick < 75) rq.nbytes = SIZE_W'($urandom_range(1, 512));
			else if (pick < 90) rq.nbytes = SIZE_W'($urandom_range(0, 8));
		end else begin
			if (pick < 80 && us_cnt > 0)
				rq.ptr = ADDR_IN_W'(us_start[$urandom_range(0, us_cnt - 1)]);
			else if (pick < 85) rq.ptr = NULL_ADDR;
		end
		return rq;
	endfunction

	// stimulus
	initial begin
		dir_row_t  rows[$];
		int unsigned burst;
		in_valid   = 0;
		cmd        = CMD_ALLOC;
		req_bytes  = 0;
		address    = 0;
		arst_n     = 0;
		mismatches = 0;
		stim_done  = 0;
		fr_start[0] = 0;
		fr_len[0]   = HEAP_WORDS;
		fr_cnt      = 1;
		us_cnt      = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table: zero size, null, unknown, full heap, splits, frees
		rows.push_back('{'{CMD_ALLOC, 16'd0, 13'd0},        1, '{NULL_ADDR, STAT_NOFIT}});
		rows.push_back('{'{CMD_FREE, 16'hFFFF, NULL_ADDR},  1, '{NULL_ADDR, STAT_NULL}});
		rows.push_back('{'{CMD_FREE, 16'd0, 13'h1FFF},      1, '{NULL_ADDR, STAT_NOTFOUND}});
		rows.push_back('{'{CMD_FREE, 16'd0, 13'd0},         1, '{NULL_ADDR, STAT_NOTFOUND}});
		rows.push_back('{'{CMD_ALLOC, 16'hFFFF, 13'h1FFF},  1, '{NULL_ADDR, STAT_NOFIT}});
		rows.push_back('{'{CMD_ALLOC, 16'd32768, 13'd0},    1, '{13'd0, STAT_OK}});
		rows.push_back('{'{CMD_ALLOC, 16'd1, 13'd0},        1, '{NULL_ADDR, STAT_NOFIT}});
		rows.push_back('{'{CMD_FREE, 16'd0, 13'd0},         1, '{NULL_ADDR, STAT_OK}});
		rows.push_back('{'{CMD_ALLOC, 16'd1, 13'd0},        1, '{13'd0, STAT_OK}});
		rows.push_back('{'{CMD_ALLOC, 16'd9, 13'd0},        1, '{13'd1, STAT_OK}});
		rows.push_back('{'{CMD_ALLOC, 16'd8, 13'd0},        1, '{13'd3, STAT_OK}});
		rows.push_back('{'{CMD_FREE, 16'd0, 13'd1},         1, '{NULL_ADDR, STAT_OK}});
		rows.push_back('{'{CMD_FREE, 16'd0, 13'd1},         1, '{NULL_ADDR, STAT_NOTFOUND}});
		rows.push_back('{'{CMD_ALLOC, 16'd8, 13'd0},        0, '{NULL_ADDR, STAT_OK}});
		rows.push_back('{'{CMD_FREE, 16'd0, 13'd0},         0, '{NULL_ADDR, STAT_OK}});
		rows.push_back('{'{CMD_FREE, 16'd0, 13'd3},         0, '{NULL_ADDR, STAT_OK}});
		rows.push_back('{'{CMD_ALLOC, 16'd24, 13'd0},       0, '{NULL_ADDR, STAT_OK}});
		foreach (rows[i]) begin
			send_request(rows[i].req, rows[i].known, rows[i].res);
			if ($urandom_range(0, 2) == 0) pause_sender();
		end

		// fill the used list to its limit with one-word chunks
		for (int i = 0; i < LIST_ENTRIES + 2; i++)
			send_request('{CMD_ALLOC, 16'd8, 13'd0}, 0, '{NULL_ADDR, STAT_OK});
		// free chunks at even positions of the shrinking used list to fill the free list
		for (int i = 0; i < LIST_ENTRIES + 4; i += 2)
			if (us_cnt > i) send_request('{CMD_FREE, 16'd0, ADDR_IN_W'(us_start[i])},
				0, '{NULL_ADDR, STAT_OK});
		for (int i = 0; i < LIST_ENTRIES; i++)
			if (us_cnt > 0) send_request('{CMD_FREE, 16'd0, ADDR_IN_W'(us_start[0])},
				0, '{NULL_ADDR, STAT_OK});

		// random part in bursts
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
				send_request(random_request(), 0, '{NULL_ADDR, STAT_OK});
			if ($urandom_range(0, 3) != 0) pause_sender();
		end
		in_valid  <= 1'b0;
		stim_done <= 1'b1;
	end

	// receiver stall pattern, with one long hold-off early on
	initial begin
		int unsigned cyc;
		out_ready = 0;
		cyc       = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= 300 && cyc < 2300) out_ready <= 1'b0;
			else if ((cyc / 64) % 3 == 0) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// result checker
	always @(posedge clk) begin
		heap_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h/%0d", result_address, status);
			end else begin
				want = pending_results.pop_front();
				if (result_address !== want.addr || status !== want.stat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %h/%0d got %h/%0d",
							want.addr, want.stat, result_address, status);
				end
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("** first_fit_word_allocator_core: PASSED **");
		else
			$display("** first_fit_word_allocator_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
